### design/cia_pkg.sv
// Package with shared constants and types of the complex integer ALU.
package cia_pkg;

  localparam int unsigned OPERAND_WIDTH_DEF = 16;
  localparam int unsigned RES_W = 33;
  localparam int unsigned OP_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cia_op_e;

endpackage

### design/cia_if.sv
// Handshake interfaces for the operand words and the result words.
interface cia_in_if #(
  parameter int unsigned OPERAND_WIDTH = cia_pkg::OPERAND_WIDTH_DEF
);
  logic                            valid;
  logic                            ready;
  logic [cia_pkg::OP_W-1:0]        operation;
  logic signed [OPERAND_WIDTH-1:0] a_re;
  logic signed [OPERAND_WIDTH-1:0] a_im;
  logic signed [OPERAND_WIDTH-1:0] b_re;
  logic signed [OPERAND_WIDTH-1:0] b_im;

  modport source (output valid, operation, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, operation, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cia_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cia_pkg::RES_W-1:0] res_re;
  logic signed [cia_pkg::RES_W-1:0] res_im;
  logic                             divide_by_zero;

  modport source (output valid, res_re, res_im, divide_by_zero, input ready);
  modport sink (input valid, res_re, res_im, divide_by_zero, output ready);
endinterface

### design/cia_div.sv
// Pipelined restoring divider for two numerators over one divisor, one quotient bit a stage.
module cia_div #(
  parameter int unsigned NW   = 33,
  parameter int unsigned DW   = 32,
  parameter int unsigned SB_W = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [NW-1:0]   num_re_i,
  input  logic [NW-1:0]   num_im_i,
  input  logic [DW-1:0]   den_i,
  input  logic [SB_W-1:0] sb_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [NW-1:0]   q_re_o,
  output logic [NW-1:0]   q_im_o,
  output logic [SB_W-1:0] sb_o
);

  logic            v_q   [NW];
  logic [DW-1:0]   rre_q [NW];
  logic [DW-1:0]   rim_q [NW];
  logic [NW-1:0]   nre_q [NW];
  logic [NW-1:0]   nim_q [NW];
  logic [DW-1:0]   den_q [NW];
  logic [SB_W-1:0] sb_q  [NW];
  logic            rdy   [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic            pv;
    logic [DW-1:0]   pre, pim, pden;
    logic [NW-1:0]   pnre, pnim;
    logic [SB_W-1:0] psb;
    logic [DW:0]     tre, tim, sre, sim;
    logic            qre, qim;
    logic            nxt_rdy;

    if (s == 0) begin : g_first
      assign pv   = in_valid_i;
      assign pre  = '0;
      assign pim  = '0;
      assign pnre = num_re_i;
      assign pnim = num_im_i;
      assign pden = den_i;
      assign psb  = sb_i;
    end else begin : g_next
      assign pv   = v_q[s-1];
      assign pre  = rre_q[s-1];
      assign pim  = rim_q[s-1];
      assign pnre = nre_q[s-1];
      assign pnim = nim_q[s-1];
      assign pden = den_q[s-1];
      assign psb  = sb_q[s-1];
    end

    if (s == NW - 1) begin : g_last
      assign nxt_rdy = out_ready_i;
    end else begin : g_mid
      assign nxt_rdy = rdy[s+1];
    end

    assign rdy[s] = !v_q[s] || nxt_rdy;

    assign tre = {pre, pnre[NW-1]};
    assign tim = {pim, pnim[NW-1]};
    assign sre = tre - {1'b0, pden};
    assign sim = tim - {1'b0, pden};
    assign qre = (tre >= {1'b0, pden});
    assign qim = (tim >= {1'b0, pden});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && pv) begin
        rre_q[s] <= qre ? sre[DW-1:0] : tre[DW-1:0];
        rim_q[s] <= qim ? sim[DW-1:0] : tim[DW-1:0];
        nre_q[s] <= {pnre[NW-2:0], qre};
        nim_q[s] <= {pnim[NW-2:0], qim};
        den_q[s] <= pden;
        sb_q[s]  <= psb;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[NW-1];
  assign q_re_o      = nre_q[NW-1];
  assign q_im_o      = nim_q[NW-1];
  assign sb_o        = sb_q[NW-1];

endmodule

### design/complex_integer_alu_top.sv
// Top level of the pipelined complex integer ALU.
//
// Channel   Dir  Contents
// in_if     in   operation, a_re, a_im, b_re, b_im
// out_if    out  res_re, res_im, divide_by_zero
//
// One word can enter every cycle while no stall backs up to the input; every word passes
// stages A, B and C, the divider's stages (one quotient bit per stage) and the output register.
// Reset clears only the valid bits of the stages.
// A stall at the output backs up stage by stage, so empty stages keep filling.
module complex_integer_alu_top #(
  parameter int unsigned OPERAND_WIDTH = cia_pkg::OPERAND_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cia_in_if.sink    in_if,
  cia_out_if.source out_if
);
  import cia_pkg::*;

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned PW   = 2 * W;
  localparam int unsigned NW   = 2 * W + 1;
  localparam int unsigned SB_W = 4 + 2 * RES_W;

  // Stage A: products and sums.
  logic                 va_q;
  cia_op_e              opa_q;
  logic                 zra_q;
  logic signed [W:0]    sre_q, sim_q;
  logic signed [PW-1:0] prr_q, pii_q, pri_q, pir_q, qrr_q, qii_q;
  logic signed [W:0]    sre_d, sim_d;

  // Stage B: combined terms.
  logic                 vb_q;
  cia_op_e              opb_q;
  logic                 zrb_q;
  logic signed [W:0]    sreb_q, simb_q;
  logic signed [NW-1:0] mre_q, mim_q, dre_q, dim_q;
  logic [PW-1:0]        den_q;

  // Stage C: divider feed.
  logic                 vc_q;
  logic [NW-1:0]        nre_q, nim_q;
  logic [PW-1:0]        denc_q;
  logic [SB_W-1:0]      sbc_q;
  logic [RES_W-1:0]     res_re_d, res_im_d;
  logic                 isdiv_d, flag_d;

  logic                 rdy_a, rdy_b, rdy_c;
  logic                 div_in_ready, div_out_valid, div_out_ready;
  logic [NW-1:0]        q_re, q_im;
  logic [SB_W-1:0]      sb_out;

  // Output register.
  logic                 vo_q;
  logic [RES_W-1:0]     ore_q, oim_q;
  logic                 oflag_q;
  logic signed [NW:0]   qs_re, qs_im;
  logic [RES_W-1:0]     fre_d, fim_d;

  assign rdy_c         = !vc_q || div_in_ready;
  assign rdy_b         = !vb_q || rdy_c;
  assign rdy_a         = !va_q || rdy_b;
  assign in_if.ready   = rdy_a;
  assign div_out_ready = !vo_q || out_if.ready;

  always_comb begin
    if (cia_op_e'(in_if.operation) == OP_SUB) begin
      sre_d = (W+1)'(in_if.a_re) - (W+1)'(in_if.b_re);
      sim_d = (W+1)'(in_if.a_im) - (W+1)'(in_if.b_im);
    end else begin
      sre_d = (W+1)'(in_if.a_re) + (W+1)'(in_if.b_re);
      sim_d = (W+1)'(in_if.a_im) + (W+1)'(in_if.b_im);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= in_if.valid;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
      if (rdy_c) begin
        vc_q <= vb_q;
      end
      if (div_out_ready) begin
        vo_q <= div_out_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && in_if.valid) begin
      opa_q <= cia_op_e'(in_if.operation);
      zra_q <= (in_if.b_re == '0) && (in_if.b_im == '0);
      sre_q <= sre_d;
      sim_q <= sim_d;
      prr_q <= in_if.a_re * in_if.b_re;
      pii_q <= in_if.a_im * in_if.b_im;
      pri_q <= in_if.a_re * in_if.b_im;
      pir_q <= in_if.a_im * in_if.b_re;
      qrr_q <= in_if.b_re * in_if.b_re;
      qii_q <= in_if.b_im * in_if.b_im;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && va_q) begin
      opb_q  <= opa_q;
      zrb_q  <= zra_q;
      sreb_q <= sre_q;
      simb_q <= sim_q;
      mre_q  <= NW'(prr_q) - NW'(pii_q);
      mim_q  <= NW'(pri_q) + NW'(pir_q);
      dre_q  <= NW'(prr_q) + NW'(pii_q);
      dim_q  <= NW'(pir_q) - NW'(pri_q);
      den_q  <= $unsigned(qrr_q) + $unsigned(qii_q);
    end
  end

  always_comb begin
    isdiv_d  = (opb_q == OP_DIV);
    flag_d   = isdiv_d && zrb_q;
    res_re_d = '0;
    res_im_d = '0;
    unique case (opb_q)
      OP_ADD, OP_SUB: begin
        res_re_d = RES_W'(sreb_q);
        res_im_d = RES_W'(simb_q);
      end
      OP_MUL: begin
        res_re_d = RES_W'(mre_q);
        res_im_d = RES_W'(mim_q);
      end
      OP_DIV: begin
        res_re_d = '0;
        res_im_d = '0;
      end
      default: begin
        res_re_d = '0;
        res_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      nre_q  <= dre_q[NW-1] ? $unsigned(-dre_q) : $unsigned(dre_q);
      nim_q  <= dim_q[NW-1] ? $unsigned(-dim_q) : $unsigned(dim_q);
      denc_q <= den_q;
      sbc_q  <= {isdiv_d, flag_d, dre_q[NW-1], dim_q[NW-1], res_re_d, res_im_d};
    end
  end

  cia_div #(
    .NW   (NW),
    .DW   (PW),
    .SB_W (SB_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vc_q),
    .in_ready_o  (div_in_ready),
    .num_re_i    (nre_q),
    .num_im_i    (nim_q),
    .den_i       (denc_q),
    .sb_i        (sbc_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (div_out_ready),
    .q_re_o      (q_re),
    .q_im_o      (q_im),
    .sb_o        (sb_out)
  );

  assign qs_re = sb_out[SB_W-3] ? -$signed({1'b0, q_re}) : $signed({1'b0, q_re});
  assign qs_im = sb_out[SB_W-4] ? -$signed({1'b0, q_im}) : $signed({1'b0, q_im});

  always_comb begin
    if (sb_out[SB_W-2]) begin
      fre_d = '0;
      fim_d = '0;
    end else if (sb_out[SB_W-1]) begin
      fre_d = RES_W'(qs_re);
      fim_d = RES_W'(qs_im);
    end else begin
      fre_d = sb_out[2*RES_W-1:RES_W];
      fim_d = sb_out[RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_out_ready && div_out_valid) begin
      ore_q   <= fre_d;
      oim_q   <= fim_d;
      oflag_q <= sb_out[SB_W-2];
    end
  end

  assign out_if.valid          = vo_q;
  assign out_if.res_re         = $signed(ore_q);
  assign out_if.res_im         = $signed(oim_q);
  assign out_if.divide_by_zero = oflag_q;

  a_zero_div_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.divide_by_zero |-> out_if.res_re == '0 && out_if.res_im == '0)
    else $error("divide by zero result is not cleared");

  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> va_q)
    else $error("accepted word did not enter the first stage");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> va_q && vb_q && vc_q)
    else $error("input stalled while a front stage is empty");

endmodule

### tb/tb_complex_integer_alu_top.sv
// Self-checking testbench of the complex integer ALU with random handshake pressure.
`timescale 1ns / 100ps

module tb_complex_integer_alu_top;
  import cia_pkg::*;

  localparam int unsigned OW = OPERAND_WIDTH_DEF;
  localparam int unsigned LATENCY = 2 * OW + 5;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned RANDOM_WORDS = 750;

  typedef struct {
    cia_op_e              op;
    logic signed [OW-1:0] a_re;
    logic signed [OW-1:0] a_im;
    logic signed [OW-1:0] b_re;
    logic signed [OW-1:0] b_im;
  } operand_word_t;

  typedef struct {
    logic signed [RES_W-1:0] re;
    logic signed [RES_W-1:0] im;
    logic                    dz;
  } result_word_t;

  logic clk_i;
  logic rst_ni;

  cia_in_if #(.OPERAND_WIDTH(OW)) in_bus ();
  cia_out_if out_bus ();

  complex_integer_alu_top #(.OPERAND_WIDTH(OW)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  operand_word_t pending_words[$];
  result_word_t  expected_results[$];
  int unsigned   words_sent;
  int unsigned   results_seen;
  int unsigned   mismatches;
  int unsigned   idle_cycles;
  int unsigned   stall_left;
  bit            stall_done;

  function automatic result_word_t complex_result(operand_word_t w);
    result_word_t r;
    longint ar;
    longint ai;
    longint br;
    longint bi;
    longint den;
    ar = w.a_re;
    ai = w.a_im;
    br = w.b_re;
    bi = w.b_im;
    r.re = '0;
    r.im = '0;
    r.dz = 1'b0;
    case (w.op)
      OP_ADD: begin
        r.re = RES_W'(ar + br);
        r.im = RES_W'(ai + bi);
      end
      OP_SUB: begin
        r.re = RES_W'(ar - br);
        r.im = RES_W'(ai - bi);
      end
      OP_MUL: begin
        r.re = RES_W'(ar * br - ai * bi);
        r.im = RES_W'(ar * bi + ai * br);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          r.re = RES_W'((ar * br + ai * bi) / den);
          r.im = RES_W'((ai * br - ar * bi) / den);
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic signed [OW-1:0] random_operand();
    case ($urandom_range(3))
      0: return OW'($signed($urandom_range(16)) - 8);
      1: return $urandom_range(1) ? {1'b0, {(OW-1){1'b1}}} : {1'b1, {(OW-1){1'b0}}};
      default: return OW'($urandom);
    endcase
  endfunction

  task automatic queue_word(cia_op_e op, int ar, int ai, int br, int bi);
    operand_word_t w;
    w.op = op;
    w.a_re = OW'(ar);
    w.a_im = OW'(ai);
    w.b_re = OW'(br);
    w.b_im = OW'(bi);
    pending_words.push_back(w);
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.operation = OP_ADD;
    in_bus.a_re = '0;
    in_bus.a_im = '0;
    in_bus.b_re = '0;
    in_bus.b_im = '0;
    out_bus.ready = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      words_sent <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        operand_word_t w;
        w.op = cia_op_e'(in_bus.operation);
        w.a_re = in_bus.a_re;
        w.a_im = in_bus.a_im;
        w.b_re = in_bus.b_re;
        w.b_im = in_bus.b_im;
        expected_results.push_back(complex_result(w));
        words_sent <= words_sent + 1;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_words.size() > 0 &&
            !((words_sent < 400 || words_sent > 550) && $urandom_range(99) < 8)) begin
          operand_word_t w;
          w = pending_words.pop_front();
          in_bus.operation <= w.op;
          in_bus.a_re <= w.a_re;
          in_bus.a_im <= w.a_im;
          in_bus.b_re <= w.b_re;
          in_bus.b_im <= w.b_im;
          in_bus.valid <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      results_seen <= 0;
      mismatches <= 0;
      stall_left <= 0;
      stall_done <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("Unexpected result word: re=%0d im=%0d dz=%0b",
                     out_bus.res_re, out_bus.res_im, out_bus.divide_by_zero);
          end
        end else begin
          result_word_t e;
          e = expected_results.pop_front();
          if (out_bus.res_re !== e.re || out_bus.res_im !== e.im ||
              out_bus.divide_by_zero !== e.dz) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("Mismatch at result %0d: expected re=%0d im=%0d dz=%0b, got re=%0d im=%0d dz=%0b",
                       results_seen, e.re, e.im, e.dz,
                       out_bus.res_re, out_bus.res_im, out_bus.divide_by_zero);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_bus.ready <= 1'b0;
      end else if (!stall_done && results_seen >= 250) begin
        stall_done <= 1'b1;
        stall_left <= 300;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= (results_seen >= 450 && results_seen < 600) ||
                         ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned total;
    cia_op_e op;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_word(OP_ADD, 32767, 32767, 32767, 32767);
    queue_word(OP_ADD, -32768, -32768, -32768, -32768);
    queue_word(OP_SUB, -32768, 32767, 32767, -32768);
    queue_word(OP_SUB, 32767, -32768, -32768, 32767);
    queue_word(OP_MUL, -32768, -32768, -32768, -32768);
    queue_word(OP_MUL, -32768, 32767, -32768, -32768);
    queue_word(OP_MUL, 32767, -32768, 32767, 32767);
    queue_word(OP_MUL, 0, 0, -32768, 32767);
    queue_word(OP_DIV, 100, -7, 0, 0);
    queue_word(OP_DIV, 0, 0, 0, 0);
    queue_word(OP_DIV, -32768, -32768, 0, 0);
    queue_word(OP_DIV, -32768, 32767, -1, 0);
    queue_word(OP_DIV, 32767, -32768, 1, 0);
    queue_word(OP_DIV, -7, 7, 2, 0);
    queue_word(OP_DIV, 7, -7, 0, 2);
    queue_word(OP_DIV, 5, 3, 1, 1);
    queue_word(OP_DIV, -32768, -32768, -32768, -32768);
    queue_word(OP_DIV, 1, -1, 32767, -32768);
    queue_word(OP_DIV, -32768, 0, 0, -1);
    queue_word(OP_MUL, -1, 1, 1, -1);
    total = pending_words.size();

    while (words_sent < total || results_seen < total) @(posedge clk_i);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      operand_word_t w;
      op = cia_op_e'($urandom_range(3));
      w.op = op;
      w.a_re = random_operand();
      w.a_im = random_operand();
      w.b_re = random_operand();
      w.b_im = random_operand();
      if (op == OP_DIV && $urandom_range(9) == 0) begin
        w.b_re = '0;
        w.b_im = '0;
      end
      pending_words.push_back(w);
    end
    total += RANDOM_WORDS;

    while (words_sent < total || expected_results.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
